// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes for the cursor line editor buffer: command and
// result words, command kind codes and the datapath control bundle.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Fixed field widths of the command and result words
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;

  // Command kind codes
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // Command word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  read_pos;
  } cle_cmd_word_t;

  // Result word
  typedef struct packed {
    logic [LEN_W-1:0]  text_length;
    logic [LEN_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] read_char;
    logic              overflow;
    logic              bad_pos;
  } cle_rsp_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic issue;   // capture command word, launch store reads
    logic commit;  // write back, update counts, load result register
  } cle_ctl_t;

endpackage

// ----- design/cle_ctrl.sv -----
// ----------------------------------------------------------------------------
// cle_ctrl
// Two-state controller: accepts a command word, then commits it once the
// result register is free or being drained. Owns the result valid flag.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cle_pkg::cle_ctl_t ctl
);
  import cle_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Handshake decode
  assign cmd_ready  = (state == ST_IDLE);
  assign ctl.issue  = cmd_valid && (state == ST_IDLE);
  assign ctl.commit = (state == ST_EXEC) && (!rsp_valid || rsp_ready);

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.issue) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (ctl.commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (ctl.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A commit always leaves a result word waiting
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> rsp_valid)
    else $error("result not presented after commit");

  // A blocked result register holds the command in execute
  a_exec_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && rsp_valid && !rsp_ready) |=> (state == ST_EXEC))
    else $error("command left execute while result was blocked");

  // No new command is taken while one is in execute
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |=> !ctl.issue)
    else $error("command issued while another was executing");

endmodule

// ----- design/cle_dp.sv -----
// ----------------------------------------------------------------------------
// cle_dp
// Datapath: before/after stacks in two single-port-write memories, the two
// stack counts, the captured command word and the result register.
// ----------------------------------------------------------------------------
module cle_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cle_pkg::cle_ctl_t      ctl,
  input  cle_pkg::cle_cmd_word_t cmd,
  output cle_pkg::cle_rsp_word_t rsp
);
  import cle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Stack storage
  logic [CHAR_W-1:0] before_mem [CAPACITY];
  logic [CHAR_W-1:0] after_mem  [CAPACITY];

  logic [CNT_W-1:0]  before_count;
  logic [CNT_W-1:0]  after_count;
  logic [CNT_W-1:0]  len;

  // Captured command word and registered store read data
  logic [KIND_W-1:0] kind_q;
  logic [CHAR_W-1:0] char_q;
  logic [POS_W-1:0]  pos_q;
  logic [CHAR_W-1:0] before_rd;
  logic [CHAR_W-1:0] after_rd;

  logic [PW-1:0]     pos_in;
  logic [AW-1:0]     before_raddr;
  logic [AW-1:0]     after_raddr;

  logic [CNT_W-1:0]  before_count_next;
  logic [CNT_W-1:0]  after_count_next;
  logic [CNT_W-1:0]  len_next;
  logic [31:0]       len_wide;
  logic [31:0]       cur_wide;
  logic [CHAR_W-1:0] rd_char;
  logic              ovf;
  logic              bad;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     len_ext;
  logic              b_we;
  logic [AW-1:0]     b_waddr;
  logic [CHAR_W-1:0] b_wdata;
  logic              a_we;
  logic [AW-1:0]     a_waddr;

  assign len = before_count + after_count;

  // Read addresses at issue: top of a stack for moves, text position for reads
  assign pos_in       = PW'(cmd.read_pos);
  assign before_raddr = (cmd.kind == KIND_LEFT) ? AW'(before_count - 1'b1)
                                                : AW'(pos_in);
  assign after_raddr  = (cmd.kind == KIND_RIGHT) ? AW'(after_count - 1'b1)
                                                 : AW'(PW'(len) - pos_in - 1'b1);

  // Command capture
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      kind_q <= cmd.kind;
      char_q <= cmd.char_in;
      pos_q  <= cmd.read_pos;
    end
  end

  // Execute: count updates, write-back and status
  assign pos_ext = PW'(pos_q);
  assign len_ext = PW'(len);

  always_comb begin
    before_count_next = before_count;
    after_count_next  = after_count;
    rd_char           = '0;
    ovf               = 1'b0;
    bad               = 1'b0;
    b_we              = 1'b0;
    b_waddr           = AW'(before_count);
    b_wdata           = after_rd;
    a_we              = 1'b0;
    a_waddr           = AW'(after_count);
    unique case (kind_q)
      KIND_LEFT: begin
        if (before_count != '0) begin
          before_count_next = before_count - 1'b1;
          after_count_next  = after_count + 1'b1;
          a_we              = 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (after_count != '0) begin
          after_count_next  = after_count - 1'b1;
          before_count_next = before_count + 1'b1;
          b_we              = 1'b1;
        end
      end
      KIND_BACK: begin
        if (before_count != '0) before_count_next = before_count - 1'b1;
      end
      KIND_INSERT: begin
        if (len >= CNT_W'(CAPACITY)) begin
          ovf = 1'b1;
        end else begin
          before_count_next = before_count + 1'b1;
          b_we              = 1'b1;
          b_wdata           = char_q;
        end
      end
      KIND_READ: begin
        if (pos_ext >= len_ext) begin
          bad = 1'b1;
        end else if (pos_ext < PW'(before_count)) begin
          rd_char = before_rd;
        end else begin
          rd_char = after_rd;
        end
      end
      default: begin
        // unused kind codes: status only
      end
    endcase
  end

  assign len_next = before_count_next + after_count_next;
  assign len_wide = 32'(len_next);
  assign cur_wide = 32'(before_count_next);

  // Before stack memory
  always_ff @(posedge clk) begin
    if (ctl.commit && b_we) before_mem[b_waddr] <= b_wdata;
    if (ctl.issue) before_rd <= before_mem[before_raddr];
  end

  // After stack memory
  always_ff @(posedge clk) begin
    if (ctl.commit && a_we) after_mem[a_waddr] <= before_rd;
    if (ctl.issue) after_rd <= after_mem[after_raddr];
  end

  // Stack counts
  always_ff @(posedge clk) begin
    if (rst) begin
      before_count <= '0;
      after_count  <= '0;
    end else if (ctl.commit) begin
      before_count <= before_count_next;
      after_count  <= after_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp.text_length <= len_wide[LEN_W-1:0];
      rsp.cursor_pos  <= cur_wide[LEN_W-1:0];
      rsp.read_char   <= rd_char;
      rsp.overflow    <= ovf;
      rsp.bad_pos     <= bad;
    end
  end

  // Text never exceeds capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    (32'(before_count) + 32'(after_count)) <= 32'(CAPACITY))
    else $error("text length beyond capacity");

  // Counts only move on commit
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!ctl.commit && !rst) |=> ($stable(before_count) && $stable(after_count)))
    else $error("stack count changed without commit");

endmodule

// ----- design/cursor_line_editor_buffer.sv -----
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer
// Text line buffer with a cursor, held as two stacks around the cursor.
// ----------------------------------------------------------------------------
// Each command word (left, right, backspace, insert, read) yields one result
// word with the length and cursor position after the command. On accept, a
// command launches reads of both stack memories through their single
// registered read ports; at commit it writes back and loads the result
// register. If the previous result is still waiting, the commit holds until
// it is taken. Inserts into a full buffer are dropped and flagged; reads at
// or past the end are flagged and return zero. Store contents need no
// clearing after reset; only the two counts are reset.
// ----------------------------------------------------------------------------
module cursor_line_editor_buffer #(
  parameter int CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cle_pkg::cle_cmd_word_t cmd,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output cle_pkg::cle_rsp_word_t rsp
);
  import cle_pkg::*;

  cle_ctl_t ctl;

  // Sequencer
  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl)
  );

  // Stacks, counts and result register
  cle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

// ----- tb/cursor_line_editor_buffer_tb.sv -----
// ----------------------------------------------------------------------------
// cursor_line_editor_buffer_tb
// Self-checking bench for the two-stack line buffer. A short scripted run
// covers the empty-buffer corners and small edits. Random edit commands then
// run under three idling mixes. The last stretch fills the buffer to capacity
// for overflow and full-range reads. Every result word is checked against a
// local model of the two stacks, or against the status typed into the script.
// ----------------------------------------------------------------------------
module cursor_line_editor_buffer_tb;
  import cle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY         = 1024;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int HOLD_OFF_CYCLES  = 200;
  localparam int DRAIN_CYCLES     = 10;

  // Kind codes with no operation behind them
  localparam logic [KIND_W-1:0] KIND_NOP_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOP_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP_7 = 3'd7;

  localparam logic [CHAR_W-1:0] CH_L = "L";
  localparam logic [CHAR_W-1:0] CH_D = "D";
  localparam logic [CHAR_W-1:0] CH_B = "B";
  localparam logic [CHAR_W-1:0] CH_P = "P";

  typedef struct {
    cle_cmd_word_t word;
    bit            typed;
    cle_rsp_word_t status;
  } edit_row_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  cle_cmd_word_t cmd       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  cle_rsp_word_t rsp;

  // Model of the two stacks
  logic [CHAR_W-1:0] text_before [CAPACITY];
  logic [CHAR_W-1:0] text_after  [CAPACITY];
  int                n_before = 0;
  int                n_after  = 0;

  cle_rsp_word_t expected_status [$];
  int            fail_count    = 0;
  int            tx_idle_pct   = 0;
  int            rx_idle_pct   = 0;
  bit            hold_off_req  = 1'b0;

  cursor_line_editor_buffer #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one edit command to the model and return the status it reports
  function automatic cle_rsp_word_t apply_edit(cle_cmd_word_t c);
    cle_rsp_word_t s;
    int            p;
    s = '0;
    p = c.read_pos;
    case (c.kind)
      KIND_LEFT: begin
        if (n_before > 0) begin
          n_before--;
          text_after[n_after] = text_before[n_before];
          n_after++;
        end
      end
      KIND_RIGHT: begin
        if (n_after > 0) begin
          n_after--;
          text_before[n_before] = text_after[n_after];
          n_before++;
        end
      end
      KIND_BACK: begin
        if (n_before > 0) n_before--;
      end
      KIND_INSERT: begin
        if (n_before + n_after >= CAPACITY) begin
          s.overflow = 1'b1;
        end else begin
          text_before[n_before] = c.char_in;
          n_before++;
        end
      end
      KIND_READ: begin
        if (p >= n_before + n_after) s.bad_pos = 1'b1;
        else if (p < n_before) s.read_char = text_before[p];
        else s.read_char = text_after[n_after - 1 - (p - n_before)];
      end
      default: ;
    endcase
    s.text_length = LEN_W'(n_before + n_after);
    s.cursor_pos  = LEN_W'(n_before);
    return s;
  endfunction

  function automatic edit_row_t row(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                    logic [POS_W-1:0] pos, int typed, int len, int cur,
                                    int rd, int ovf, int bad);
    edit_row_t r;
    r.word.kind          = kind;
    r.word.char_in       = ch;
    r.word.read_pos      = pos;
    r.typed              = (typed != 0);
    r.status.text_length = LEN_W'(len);
    r.status.cursor_pos  = LEN_W'(cur);
    r.status.read_char   = CHAR_W'(rd);
    r.status.overflow    = (ovf != 0);
    r.status.bad_pos     = (bad != 0);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one command word; on acceptance log what it should report
  task automatic offer_word(cle_cmd_word_t w, bit typed, cle_rsp_word_t status);
    cle_rsp_word_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (!cmd_ready);
    predicted = apply_edit(w);
    expected_status.insert(expected_status.size(), typed ? status : predicted);
  endtask

  task automatic send_edit(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                           logic [POS_W-1:0] pos);
    cle_cmd_word_t w;
    w.kind     = kind;
    w.char_in  = ch;
    w.read_pos = pos;
    offer_word(w, 1'b0, '0);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    cle_rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_status.size() == 0) begin
        $error("result word with no command outstanding");
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("text_length", want.text_length, rsp.text_length);
        check_field("cursor_pos",  want.cursor_pos,  rsp.cursor_pos);
        check_field("read_char",   want.read_char,   rsp.read_char);
        check_field("overflow",    want.overflow,    rsp.overflow);
        check_field("bad_pos",     want.bad_pos,     rsp.bad_pos);
      end
    end
  end

  // Stimulus
  initial begin
    edit_row_t         script [$];
    logic [KIND_W-1:0] k;
    int                r;
    int                len;
    int                pos;

    // Empty-buffer corners, small edits, unused kinds
    script.insert(script.size(), row(KIND_LEFT,   8'h00, 10'd0,    1, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_RIGHT,  8'h00, 10'd0,    1, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_BACK,   8'hFF, 10'd1023, 1, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd0,    1, 0, 0, 0, 0, 1));
    script.insert(script.size(), row(KIND_READ,   8'hFF, 10'd1023, 1, 0, 0, 0, 0, 1));
    script.insert(script.size(), row(KIND_NOP_5,  8'hFF, 10'd1023, 1, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, 8'h00, 10'd0,    1, 1, 1, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, 8'hFF, 10'd1023, 1, 2, 2, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, CH_L,  10'd0,    1, 3, 3, 0, 0, 0));
    script.insert(script.size(), row(KIND_LEFT,   8'h00, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_LEFT,   8'h00, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, CH_D,  10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd1,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd2,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd3,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd4,    1, 4, 2, 0, 0, 1));
    script.insert(script.size(), row(KIND_RIGHT,  8'h00, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_BACK,   8'h00, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_NOP_6,  8'h5A, 10'd2,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_NOP_7,  8'hA5, 10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, CH_B,  10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_INSERT, CH_P,  10'd0,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_READ,   8'h00, 10'd4,    0, 0, 0, 0, 0, 0));
    script.insert(script.size(), row(KIND_LEFT,   8'h00, 10'd0,    0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 18;
    rx_idle_pct = 54;
    foreach (script[i]) offer_word(script[i].word, script[i].typed, script[i].status);

    // Random edits under three idling mixes; long result stall in the last
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 54 : 0;
      rx_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 18 : 0;
      if (ph == 2) hold_off_req = 1'b1;
      repeat (RANDOM_PER_PHASE) begin
        len = n_before + n_after;
        r   = $urandom_range(99);
        if (r < 30)      k = KIND_INSERT;
        else if (r < 45) k = KIND_LEFT;
        else if (r < 60) k = KIND_RIGHT;
        else if (r < 75) k = KIND_BACK;
        else if (r < 95) k = KIND_READ;
        else             k = KIND_NOP_5 + KIND_W'($urandom_range(2));
        // mostly in-range reads, some past the end
        if (len > 0 && $urandom_range(3) != 0) pos = $urandom_range(len - 1);
        else pos = $urandom_range(1023);
        send_edit(k, CHAR_W'($urandom_range(255)), POS_W'(pos));
      end
    end

    // Fill to capacity, with a few cursor moves and reads mixed in
    while (n_before + n_after < CAPACITY) begin
      r = $urandom_range(99);
      if (r < 90)      k = KIND_INSERT;
      else if (r < 95) k = KIND_LEFT;
      else if (r < 98) k = KIND_RIGHT;
      else             k = KIND_READ;
      send_edit(k, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(1023)));
    end

    // Full buffer: dropped inserts, reads at both ends, cursor to the end
    repeat (3) send_edit(KIND_INSERT, CHAR_W'($urandom_range(255)), 10'd0);
    send_edit(KIND_READ, 8'h00, 10'd1023);
    send_edit(KIND_READ, 8'h00, 10'd0);
    while (n_after > 0) send_edit(KIND_RIGHT, 8'h00, 10'd0);
    send_edit(KIND_RIGHT, 8'h00, 10'd0);
    send_edit(KIND_READ, 8'h00, 10'd1023);
    send_edit(KIND_INSERT, 8'hFF, 10'd0);
    repeat (3) send_edit(KIND_LEFT, 8'h00, 10'd0);
    send_edit(KIND_READ, 8'h00, 10'd1023);
    send_edit(KIND_READ, 8'h00, 10'd1021);
    send_edit(KIND_BACK, 8'h00, 10'd0);
    send_edit(KIND_READ, 8'h00, 10'd1023);
    send_edit(KIND_INSERT, 8'hC3, 10'd0);
    send_edit(KIND_INSERT, 8'h3C, 10'd0);
    send_edit(KIND_READ, 8'h00, 10'd1020);

    @(negedge clk);
    cmd_valid <= 1'b0;

    // Drain and settle
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
